FILE: design/utf8_sanitize_stream_assert.svh
// Assertion macros shared by the sanitizer modules.
`ifndef UTF8_SANITIZE_STREAM_ASSERT_SVH
`define UTF8_SANITIZE_STREAM_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define UTF8S_CHECK(lbl, clk_s, rst_s, prop) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) \
		else $error("utf8 sanitizer check failed");

// Condition in one cycle implies a consequence in the next.
`define UTF8S_NEXT(lbl, clk_s, rst_s, cond, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (cond) |=> (cons)) \
		else $error("utf8 sanitizer sequencing check failed");

`endif

FILE: design/utf8s_pkg.sv
// Types and constants shared by the UTF-8 sanitizer modules.
package utf8s_pkg;

	localparam int MaxResults = 4;

	typedef logic [7:0] byte_t;

	localparam byte_t QMARK     = 8'h3F;
	localparam byte_t LEAD2_LO  = 8'hC2;
	localparam byte_t LEAD3_LO  = 8'hE0;
	localparam byte_t LEAD4_LO  = 8'hF0;
	localparam byte_t LEAD4_HI  = 8'hF4;
	localparam byte_t LEAD_SURR = 8'hED;
	localparam byte_t CONT_LO   = 8'h80;
	localparam byte_t SEC_A0    = 8'hA0;
	localparam byte_t SEC_90    = 8'h90;
	localparam byte_t SEC_8F    = 8'h8F;

	// Results caused by one input byte; the terminator, if any, is the last slot used.
	typedef struct packed {
		logic [MaxResults-1:0][7:0] data;
		logic [2:0]                 count;
		logic                       eos;
	} entry_t;

endpackage

FILE: design/utf8_sanitize_stream.sv
// Top level of the streaming UTF-8 sanitizer.
// Bytes of a zero-terminated string enter on s_axis one per cycle while the entry queue has room;
// each byte turns at once into a queue entry of zero to four results, and the back end sends
// those results on m_axis one per cycle from an output register, so input and output stall
// independently. While the sink stays ready, well-formed text sustains one byte in and one result
// out per cycle, each accepted byte passing through the entry queue and then the output register;
// a broken sequence or a terminator after held bytes gives up to four results for one byte, and
// the input stalls only once QUEUE_DEPTH entries, the one being drained included, are queued.
// tlast marks the last result caused by one byte, tuser the terminator result.
module utf8_sanitize_stream
	import utf8s_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s_axis_tvalid,
	output logic  s_axis_tready,
	input  byte_t s_axis_tdata,    // [7:0] in_byte
	output logic  m_axis_tvalid,
	input  logic  m_axis_tready,
	output byte_t m_axis_tdata,    // [7:0] out_byte
	output logic  m_axis_tlast,    // last_of_run
	output logic  m_axis_tuser     // [0] end_of_string
);

	logic   push;
	entry_t push_entry;
	logic   pop;
	entry_t head;
	logic   empty;
	logic   full;

	utf8s_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.q_full       (full),
		.push         (push),
		.push_entry   (push_entry)
	);

	utf8s_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.head      (head),
		.empty     (empty),
		.full      (full)
	);

	utf8s_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.empty        (empty),
		.pop          (pop),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tuser (m_axis_tuser)
	);

endmodule

FILE: design/utf8s_front.sv
// Front end: accepts bytes, tracks the open sequence and builds result entries.
`include "utf8_sanitize_stream_assert.svh"

module utf8s_front
	import utf8s_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   s_axis_tvalid,
	output logic   s_axis_tready,
	input  byte_t  s_axis_tdata,   // [7:0] in_byte
	input  logic   q_full,
	output logic   push,
	output entry_t push_entry
);

	logic [1:0] hc_q;
	logic [2:0] len_q;
	byte_t      held_q [3];

	byte_t      b;
	logic       accept;
	logic       cont;
	logic       sec_ok;
	logic       ok;
	logic       complete;
	logic       fail;
	logic       use_lead;
	logic       lead_emit;
	logic       lead_eos;
	byte_t      lead_byte;
	logic [2:0] lead_len;
	logic [1:0] pre;
	logic       tail;

	assign b             = s_axis_tdata;
	assign s_axis_tready = !q_full;
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_comb begin
		cont   = (b & 8'hC0) == CONT_LO;
		sec_ok = cont;
		if (held_q[0] == LEAD3_LO && b < SEC_A0) sec_ok = 1'b0;
		if (held_q[0] == LEAD_SURR && b >= SEC_A0) sec_ok = 1'b0;
		if (held_q[0] == LEAD4_LO && b < SEC_90) sec_ok = 1'b0;
		if (held_q[0] == LEAD4_HI && b > SEC_8F) sec_ok = 1'b0;
		ok = (hc_q == 2'd1) ? sec_ok : cont;
	end

	// Lead byte rules for a byte that starts fresh.
	always_comb begin
		lead_emit = 1'b0;
		lead_eos  = 1'b0;
		lead_byte = b;
		lead_len  = 3'd0;
		if (b == 8'h00) begin
			lead_emit = 1'b1;
			lead_eos  = 1'b1;
		end else if (b < CONT_LO) begin
			lead_emit = 1'b1;
		end else if (b >= LEAD2_LO && b < LEAD3_LO) begin
			lead_len = 3'd2;
		end else if (b >= LEAD3_LO && b < LEAD4_LO) begin
			lead_len = 3'd3;
		end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
			lead_len = 3'd4;
		end else begin
			lead_emit = 1'b1;
			lead_byte = QMARK;
		end
	end

	always_comb begin
		complete = (hc_q != 2'd0) && ok && (({1'b0, hc_q} + 3'd1) == len_q);
		fail     = (hc_q != 2'd0) && !ok;
		use_lead = (hc_q == 2'd0) || fail;
		pre      = (complete || fail) ? hc_q : 2'd0;
		tail     = complete || (use_lead && lead_emit);

		push_entry.count = {1'b0, pre} + {2'b00, tail};
		push_entry.eos   = use_lead && lead_eos;
		for (int i = 0; i < MaxResults; i++) begin
			push_entry.data[i] = 8'h00;
			if (i == int'(pre)) begin
				push_entry.data[i] = complete ? b : lead_byte;
			end
		end
		// Held bytes on completion, '?' for each on a break.
		for (int i = 0; i < 3; i++) begin
			if (i < int'(pre)) begin
				push_entry.data[i] = complete ? held_q[i] : QMARK;
			end
		end
		push = accept && (push_entry.count != 3'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hc_q  <= 2'd0;
			len_q <= 3'd0;
		end else if (accept) begin
			if (use_lead) begin
				hc_q  <= (lead_len != 3'd0) ? 2'd1 : 2'd0;
				len_q <= lead_len;
			end else if (complete) begin
				hc_q  <= 2'd0;
				len_q <= 3'd0;
			end else begin
				hc_q <= hc_q + 2'd1;
			end
		end
	end

	// Held bytes carry no reset; only entries below the count are read.
	always_ff @(posedge clk) begin
		if (accept) begin
			if (use_lead) begin
				if (lead_len != 3'd0) held_q[0] <= b;
			end else if (!complete) begin
				held_q[hc_q] <= b;
			end
		end
	end

	`UTF8S_CHECK(a_hc_below_len, clk, arst_n, (hc_q == 2'd0) || ({1'b0, hc_q} < len_q))
	`UTF8S_CHECK(a_eos_ends_entry, clk, arst_n,
		!(push && push_entry.eos) || (push_entry.data[push_entry.count[1:0] - 2'd1] == 8'h00))
	`UTF8S_NEXT(a_eos_clears_state, clk, arst_n, push && push_entry.eos, hc_q == 2'd0)

endmodule

FILE: design/utf8s_queue.sv
// Short queue of result entries between the front and the back end.
`include "utf8_sanitize_stream_assert.svh"

module utf8s_queue
	import utf8s_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	input  logic   pop,
	output entry_t head,
	output logic   empty,
	output logic   full
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t        mem_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign empty = (cnt_q == CW'(0));
	assign full  = (cnt_q == CW'(DEPTH));
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			if (pop)  rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			if (push && !pop) cnt_q <= cnt_q + CW'(1);
			else if (pop && !push) cnt_q <= cnt_q - CW'(1);
		end
	end

	`UTF8S_CHECK(a_cnt_bound, clk, arst_n, cnt_q <= CW'(DEPTH))
	`UTF8S_CHECK(a_no_push_full, clk, arst_n, !(push && full))
	`UTF8S_NEXT(a_push_fills, clk, arst_n, push && !pop, cnt_q == $past(cnt_q) + CW'(1))

endmodule

FILE: design/utf8s_back.sv
// Back end: walks each queued entry and drives one result per cycle while the sink is ready.
`include "utf8_sanitize_stream_assert.svh"

module utf8s_back
	import utf8s_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  entry_t head,
	input  logic   empty,
	output logic   pop,
	output logic   m_axis_tvalid,
	input  logic   m_axis_tready,
	output byte_t  m_axis_tdata,   // [7:0] out_byte
	output logic   m_axis_tlast,   // last_of_run
	output logic   m_axis_tuser    // [0] end_of_string
);

	logic [1:0] idx_q;
	logic       out_valid_q;
	byte_t      out_data_q;
	logic       out_last_q;
	logic       out_eos_q;
	logic       load;
	logic       last_slot;

	assign load      = !empty && (!out_valid_q || m_axis_tready);
	assign last_slot = ({1'b0, idx_q} == (head.count - 3'd1));
	assign pop       = load && last_slot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= last_slot ? 2'd0 : idx_q + 2'd1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_data_q <= head.data[idx_q];
			out_last_q <= last_slot;
			out_eos_q  <= last_slot && head.eos;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_eos_q;

	`UTF8S_CHECK(a_head_nonempty, clk, arst_n, empty || (head.count != 3'd0))
	`UTF8S_CHECK(a_idx_in_entry, clk, arst_n, empty || ({1'b0, idx_q} < head.count))
	`UTF8S_CHECK(a_eos_is_last, clk, arst_n, !(m_axis_tvalid && m_axis_tuser) || m_axis_tlast)

endmodule

FILE: verif/tb_utf8_sanitize_stream.sv
// Self-checking testbench for the streaming UTF-8 sanitizer: directed table, then random text.
`timescale 1ns / 100ps

module tb_utf8_sanitize_stream;
	import utf8s_pkg::*;

	localparam int N_DIRECTED   = 25;
	localparam int RANDOM_ITEMS = 440;
	localparam int QUIET_TAIL   = 80;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT  = 200000;

	typedef struct {
		byte_t din;
		bit    typed;
		byte_t dout;
		bit    eos;
	} stim_row_t;

	typedef struct {
		byte_t data;
		logic  last;
		logic  eos;
	} out_beat_t;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  s_axis_tvalid = 1'b0;
	logic  s_axis_tready;
	byte_t s_axis_tdata = '0;
	logic  m_axis_tvalid;
	logic  m_axis_tready = 1'b0;
	byte_t m_axis_tdata;    // [7:0] out_byte
	logic  m_axis_tlast;    // last_of_run
	logic  m_axis_tuser;    // [0] end_of_string

	utf8_sanitize_stream dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	// Directed rows: expected result typed in only for single, obvious outcomes.
	stim_row_t dir_tab [N_DIRECTED] = '{
		'{8'h00, 1'b1, 8'h00, 1'b1},   // terminator straight after reset
		'{8'h7F, 1'b1, 8'h7F, 1'b0},
		'{8'hFF, 1'b1, QMARK, 1'b0},
		'{8'h80, 1'b1, QMARK, 1'b0},   // stray continuation
		'{8'hC2, 1'b0, 8'h00, 1'b0},
		'{8'h80, 1'b0, 8'h00, 1'b0},
		'{8'hE0, 1'b0, 8'h00, 1'b0},
		'{8'h9F, 1'b0, 8'h00, 1'b0},   // overlong three-byte form
		'{8'hED, 1'b0, 8'h00, 1'b0},
		'{8'hA0, 1'b0, 8'h00, 1'b0},   // surrogate
		'{8'hF0, 1'b0, 8'h00, 1'b0},
		'{8'h90, 1'b0, 8'h00, 1'b0},
		'{8'h80, 1'b0, 8'h00, 1'b0},
		'{8'hBF, 1'b0, 8'h00, 1'b0},
		'{8'hF4, 1'b0, 8'h00, 1'b0},
		'{8'h90, 1'b0, 8'h00, 1'b0},   // above U+10FFFF
		'{8'hF4, 1'b0, 8'h00, 1'b0},
		'{8'h8F, 1'b0, 8'h00, 1'b0},
		'{8'h41, 1'b0, 8'h00, 1'b0},   // break with two held, ASCII passes
		'{8'hF1, 1'b0, 8'h00, 1'b0},
		'{8'h80, 1'b0, 8'h00, 1'b0},
		'{8'h80, 1'b0, 8'h00, 1'b0},
		'{8'hC2, 1'b0, 8'h00, 1'b0},   // break with three held, new lead held
		'{8'h00, 1'b0, 8'h00, 1'b0},   // terminator with a lead held
		'{8'hC1, 1'b1, QMARK, 1'b0}
	};

	stim_row_t stim_q [$];
	out_beat_t pending_out [$];
	out_beat_t byte_results [$];

	// Predictor state
	byte_t      held_b [3];
	logic [1:0] held_cnt;
	logic [2:0] seq_len;

	int idle_pct;
	int cycle_cnt;
	int mismatches;
	int bytes_sent;
	int results_seen;
	int strings_done;

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 40)
			$display("MISMATCH @%0t: %s", $time, msg);
	endtask

	function automatic void add_result(input byte_t b, input logic eos);
		byte_results.push_back('{data: b, last: 1'b0, eos: eos});
	endfunction

	function automatic bit is_cont(input byte_t b);
		return (b & 8'hC0) == CONT_LO;
	endfunction

	function automatic bit second_ok(input byte_t lead, input byte_t b);
		if (!is_cont(b)) return 1'b0;
		if (lead == LEAD3_LO && b < SEC_A0) return 1'b0;
		if (lead == LEAD_SURR && b >= SEC_A0) return 1'b0;
		if (lead == LEAD4_LO && b < SEC_90) return 1'b0;
		if (lead == LEAD4_HI && b > SEC_8F) return 1'b0;
		return 1'b1;
	endfunction

	function automatic void take_lead(input byte_t b);
		held_cnt = '0;
		seq_len = '0;
		if (b == 8'h00) begin
			add_result(8'h00, 1'b1);
		end else if (b < CONT_LO) begin
			add_result(b, 1'b0);
		end else if (b >= LEAD2_LO && b < LEAD3_LO) begin
			held_b[0] = b; held_cnt = 2'd1; seq_len = 3'd2;
		end else if (b >= LEAD3_LO && b < LEAD4_LO) begin
			held_b[0] = b; held_cnt = 2'd1; seq_len = 3'd3;
		end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
			held_b[0] = b; held_cnt = 2'd1; seq_len = 3'd4;
		end else begin
			add_result(QMARK, 1'b0);
		end
	endfunction

	// Work out the results one accepted byte causes, last one flagged.
	function automatic void sanitize_byte(input byte_t b);
		int unsigned hc;
		bit ok;
		byte_results.delete();
		hc = {30'd0, held_cnt};
		if (hc >= seq_len || seq_len < 2 || seq_len > 4)
			hc = 0;
		if (hc == 0) begin
			take_lead(b);
		end else begin
			ok = (hc == 1) ? second_ok(held_b[0], b) : is_cont(b);
			if (ok && hc + 1 == seq_len) begin
				for (int i = 0; i < hc; i++) add_result(held_b[i], 1'b0);
				add_result(b, 1'b0);
				held_cnt = '0;
				seq_len = '0;
			end else if (ok) begin
				held_b[hc] = b;
				held_cnt = 2'(hc + 1);
			end else begin
				for (int i = 0; i < hc; i++) add_result(QMARK, 1'b0);
				take_lead(b);
			end
		end
		if (byte_results.size() != 0)
			byte_results[byte_results.size() - 1].last = 1'b1;
	endfunction

	function automatic stim_row_t text_row(input byte_t b);
		return '{din: b, typed: 1'b0, dout: 8'h00, eos: 1'b0};
	endfunction

	function automatic byte_t rand_cont();
		return byte_t'($urandom_range(8'hBF, CONT_LO));
	endfunction

	// Sink side: random ready bursts while idle_pct allows.
	initial begin
		@(posedge arst_n);
		forever begin
			if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
		end
	end

	always @(posedge clk) begin : check_out
		out_beat_t want;
		cycle_cnt++;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_out.size() == 0) begin
				report_mismatch($sformatf("unexpected result byte %02h", m_axis_tdata));
			end else begin
				want = pending_out.pop_front();
				results_seen++;
				if (m_axis_tdata !== want.data)
					report_mismatch($sformatf("result %0d byte %02h, want %02h",
						results_seen, m_axis_tdata, want.data));
				if (m_axis_tlast !== want.last)
					report_mismatch($sformatf("result %0d tlast %b, want %b",
						results_seen, m_axis_tlast, want.last));
				if (m_axis_tuser !== want.eos)
					report_mismatch($sformatf("result %0d tuser %b, want %b",
						results_seen, m_axis_tuser, want.eos));
			end
		end
	end

	initial begin
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
			pending_out.size());
		$display("== FAIL ==");
		$finish;
	end

	initial begin : drive
		int unsigned kind;
		byte_t lead;
		byte_t lo;
		byte_t hi;
		stim_row_t row;

		held_cnt = '0;
		seq_len = '0;
		foreach (held_b[i]) held_b[i] = 8'h00;
		idle_pct = 25;

		foreach (dir_tab[i]) stim_q.push_back(dir_tab[i]);

		// Mostly well-formed text with random content, some broken sequences and noise.
		while (stim_q.size() < N_DIRECTED + RANDOM_ITEMS) begin
			kind = $urandom_range(0, 99);
			if (kind < 30) begin
				stim_q.push_back(text_row(byte_t'($urandom_range(8'h7F, 8'h01))));
			end else if (kind < 45) begin
				stim_q.push_back(text_row(byte_t'($urandom_range(8'hDF, LEAD2_LO))));
				stim_q.push_back(text_row(rand_cont()));
			end else if (kind < 62) begin
				lead = byte_t'($urandom_range(8'hEF, LEAD3_LO));
				lo = (lead == LEAD3_LO) ? SEC_A0 : CONT_LO;
				hi = (lead == LEAD_SURR) ? 8'h9F : 8'hBF;
				stim_q.push_back(text_row(lead));
				stim_q.push_back(text_row(byte_t'($urandom_range(hi, lo))));
				stim_q.push_back(text_row(rand_cont()));
			end else if (kind < 77) begin
				lead = byte_t'($urandom_range(LEAD4_HI, LEAD4_LO));
				lo = (lead == LEAD4_LO) ? SEC_90 : CONT_LO;
				hi = (lead == LEAD4_HI) ? SEC_8F : 8'hBF;
				stim_q.push_back(text_row(lead));
				stim_q.push_back(text_row(byte_t'($urandom_range(hi, lo))));
				stim_q.push_back(text_row(rand_cont()));
				stim_q.push_back(text_row(rand_cont()));
			end else if (kind < 85) begin
				// Open a sequence, maybe extend it, then throw any byte at it
				stim_q.push_back(text_row(byte_t'($urandom_range(LEAD4_HI, LEAD2_LO))));
				if ($urandom_range(0, 1))
					stim_q.push_back(text_row(rand_cont()));
				stim_q.push_back(text_row(byte_t'($urandom_range(255, 0))));
			end else if (kind < 93) begin
				stim_q.push_back(text_row(byte_t'($urandom_range(255, 0))));
			end else begin
				stim_q.push_back(text_row(8'h00));
			end
		end
		stim_q.push_back(text_row(8'h00));

		@(posedge arst_n);
		@(posedge clk);

		for (int idx = 0; idx < stim_q.size(); idx++) begin
			row = stim_q[idx];

			// Hold off until the output has caught up completely
			if (idx == N_DIRECTED || idx == N_DIRECTED + 200) begin
				s_axis_tvalid <= 1'b0;
				do @(posedge clk); while (pending_out.size() != 0);
			end

			if (idx + QUIET_TAIL >= stim_q.size())
				idle_pct = 0;
			else if (idx % 64 == 0)
				idle_pct = $urandom_range(0, 2) * 15;

			if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end

			s_axis_tvalid <= 1'b1;
			s_axis_tdata <= row.din;
			@(posedge clk);
			while (!s_axis_tready) @(posedge clk);

			// Transaction accepted at this edge
			sanitize_byte(row.din);
			if (row.typed)
				pending_out.push_back('{data: row.dout, last: 1'b1, eos: row.eos});
			else
				foreach (byte_results[k]) pending_out.push_back(byte_results[k]);
			bytes_sent++;
			if (row.din == 8'h00)
				strings_done++;
		end
		s_axis_tvalid <= 1'b0;

		do @(posedge clk); while (pending_out.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d bytes (%0d directed) over %0d strings; checked %0d results.",
			bytes_sent, N_DIRECTED, strings_done, results_seen);
		$display("Mix: well-formed 1-4 byte sequences, broken and truncated ones, raw noise.");
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+design
design/utf8s_pkg.sv
design/utf8s_front.sv
design/utf8s_queue.sv
design/utf8s_back.sv
design/utf8_sanitize_stream.sv
verif/tb_utf8_sanitize_stream.sv
